>>> sv/ccc_pkg.sv
// calendar clock counter: shared types, constants and helper functions
// used by ccc_cell, ccc_leap and calendar_clock_counter_unit; no dependencies
package ccc_pkg;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_SET    = 1'b1;
    localparam logic HOUR_FMT_24 = 1'b0;
    localparam logic HOUR_FMT_12 = 1'b1;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int TICK_W  = 32;
    localparam int HHMM_W  = 14;

    localparam logic [SEC_W:0]   SEC_LIMIT   = 7'd60;
    localparam logic [MIN_W:0]   MIN_LIMIT   = 7'd60;
    localparam logic [HOUR_W:0]  HOUR_LIMIT  = 6'd24;
    localparam logic [MONTH_W:0] MONTH_LIMIT = 5'd13;
    localparam logic [YEAR_W:0]  YEAR_LIMIT  = 17'h10000;
    localparam logic [TICK_W:0]  TICK_LIMIT  = 33'h1_0000_0000;

    localparam logic [YEAR_W-1:0] YEAR_RESET = 16'd2000;
    localparam logic [YEAR_W-1:0] YEAR_MAX   = 16'hFFFF;

    // year 2000 sits on a century that is a multiple of 400
    localparam logic [6:0] CENT_RES_RESET = 7'd0;
    localparam logic [1:0] CENT_QUAD_RESET = 2'd0;
    localparam logic [6:0] CENT_RES_LAST  = 7'd99;

    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [5:0] MIN_MAX  = 6'd59;

    // floor(v / 100) for v below 16384 as (v * 5243) >> 19
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SH  = 19;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [SEC_W-1:0]   seconds;
        logic [MIN_W-1:0]   minutes;
        logic [HOUR_W-1:0]  hours;
        logic [HOUR_W-1:0]  shown_hour;
        logic               after_noon;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [TICK_W-1:0]  tick_total;
    } result_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (month >= 4'd1 && month <= 4'd12)
        begin
            len = MONTH_LEN[month - 4'd1];
            if (month == 4'd2 && leap)
            begin
                len = 5'd29;
            end
        end
        return len;
    endfunction

    function automatic logic [HOUR_W-1:0] shown_hour_of(input logic [HOUR_W-1:0] h,
                                                       input logic fmt);
        logic [HOUR_W-1:0] r;
        if (fmt == HOUR_FMT_24)
        begin
            r = h;
        end
        else
        begin
            if (h >= 5'd24)
            begin
                r = h - 5'd24;
            end
            else if (h >= 5'd12)
            begin
                r = h - 5'd12;
            end
            else
            begin
                r = h;
            end
            if (r == 5'd0)
            begin
                r = 5'd12;
            end
        end
        return r;
    endfunction

endpackage

>>> sv/ccc_cell.sv
// calendar clock counter: one wrapping counter cell of the carry chain
// depends on ccc_pkg
module ccc_cell
    import ccc_pkg::*;
#(
    parameter int               WIDTH     = 6,
    parameter logic [WIDTH-1:0] FIRST     = '0,
    parameter logic [WIDTH-1:0] RESET_VAL = '0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             carry_in,
    input  logic [WIDTH:0]   limit,
    input  logic             load,
    input  logic [WIDTH-1:0] load_value,
    output logic [WIDTH-1:0] count,
    output logic [WIDTH-1:0] count_next,
    output logic             carry_out
);

    logic [WIDTH-1:0] count_reg;
    logic [WIDTH:0]   inc;
    logic             wrap;

    assign inc  = (WIDTH+1)'(count_reg) + (WIDTH+1)'(1);
    assign wrap = (inc >= limit);

    always_comb
    begin
        if (load)
        begin
            count_next = load_value;
        end
        else if (carry_in)
        begin
            count_next = wrap ? FIRST : inc[WIDTH-1:0];
        end
        else
        begin
            count_next = count_reg;
        end
    end

    assign carry_out = carry_in & wrap & ~load;
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RESET_VAL;
        end
        else if (advance)
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/ccc_leap.sv
// calendar clock counter: leap year tracking by century residues of the year
// depends on ccc_pkg
module ccc_leap
    import ccc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              year_carry,
    input  logic [YEAR_W-1:0] year,
    output logic              leap
);

    // cent_res is year mod 100, cent_quad is (year / 100) mod 4
    logic [6:0] cent_res_reg;
    logic [6:0] cent_res_next;
    logic [1:0] cent_quad_reg;
    logic [1:0] cent_quad_next;

    assign leap = (year[1:0] == 2'd0) &&
                  ((cent_res_reg != 7'd0) || (cent_quad_reg == 2'd0));

    always_comb
    begin
        cent_res_next  = cent_res_reg;
        cent_quad_next = cent_quad_reg;
        if (year_carry)
        begin
            if (year == YEAR_MAX)
            begin
                // year wraps to zero
                cent_res_next  = 7'd0;
                cent_quad_next = 2'd0;
            end
            else if (cent_res_reg == CENT_RES_LAST)
            begin
                cent_res_next  = 7'd0;
                cent_quad_next = cent_quad_reg + 2'd1;
            end
            else
            begin
                cent_res_next = cent_res_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cent_res_reg  <= CENT_RES_RESET;
            cent_quad_reg <= CENT_QUAD_RESET;
        end
        else if (advance)
        begin
            cent_res_reg  <= cent_res_next;
            cent_quad_reg <= cent_quad_next;
        end
    end

endmodule

>>> sv/calendar_clock_counter_unit.sv
// calendar clock counter: top level, carry chain of counter cells and output stage
// depends on ccc_pkg, ccc_cell, ccc_leap
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | in_valid, in_stall | mode, set_hhmm
//  output   | out_valid, out_stall | seconds minutes hours shown_hour after_noon
//           |                    | day month year tick_total
//  config   | cfg_write          | cfg_data (hour format)
//
// one item per cycle while in_stall is low; the whole seconds-to-year carry
// ripple is combinational; each result is registered on the way to the output
// reset gives 00:00:00 on 1 january 2000, tick count zero, 24-hour format
// an output register plus one skid register keep input transfers going while
// the output is stalled; in_stall rises only once both are full
module calendar_clock_counter_unit
    import ccc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [HHMM_W-1:0]   set_hhmm,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SEC_W-1:0]    seconds,
    output logic [MIN_W-1:0]    minutes,
    output logic [HOUR_W-1:0]   hours,
    output logic [HOUR_W-1:0]   shown_hour,
    output logic                after_noon,
    output logic [DAY_W-1:0]    day,
    output logic [MONTH_W-1:0]  month,
    output logic [YEAR_W-1:0]   year,
    output logic [TICK_W-1:0]   tick_total
);

    logic hour_format_reg;

    logic in_fire;
    logic tick;
    logic set;

    // set value split into hours and minutes
    logic [26:0]       div_prod;
    logic [7:0]        set_h_raw;
    logic [HHMM_W-1:0] set_hundreds;
    logic [HHMM_W-1:0] set_m_raw;
    logic [HOUR_W-1:0] set_h;
    logic [MIN_W-1:0]  set_m;

    logic [SEC_W-1:0]   sec_cur,   sec_nxt;
    logic [MIN_W-1:0]   min_cur,   min_nxt;
    logic [HOUR_W-1:0]  hour_cur,  hour_nxt;
    logic [DAY_W-1:0]   day_cur,   day_nxt;
    logic [MONTH_W-1:0] month_cur, month_nxt;
    logic [YEAR_W-1:0]  year_cur,  year_nxt;
    logic [TICK_W-1:0]  tick_cur,  tick_nxt;
    logic               sec_carry, min_carry, hour_carry, day_carry, month_carry;
    logic               year_carry_unused, tick_carry_unused;
    logic               leap;
    logic [DAY_W:0]     day_limit;

    result_t result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_full_reg;
    logic    out_take;

    assign in_stall = skid_full_reg;
    assign in_fire  = in_valid & ~skid_full_reg;
    assign tick     = (mode == MODE_TICK);
    assign set      = (mode == MODE_SET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_format_reg <= HOUR_FMT_24;
        end
        else if (cfg_write)
        begin
            hour_format_reg <= cfg_data;
        end
    end

    assign div_prod     = 27'(set_hhmm) * 27'(DIV100_MUL);
    assign set_h_raw    = div_prod[DIV100_SH +: 8];
    assign set_hundreds = HHMM_W'({set_h_raw, 6'b0}) + HHMM_W'({set_h_raw, 5'b0})
                        + HHMM_W'({set_h_raw, 2'b0});
    assign set_m_raw    = set_hhmm - set_hundreds;
    assign set_h        = (set_h_raw > 8'(HOUR_MAX)) ? HOUR_MAX : set_h_raw[HOUR_W-1:0];
    assign set_m        = (set_m_raw > HHMM_W'(MIN_MAX)) ? MIN_MAX : set_m_raw[MIN_W-1:0];

    ccc_cell #(.WIDTH(SEC_W), .FIRST('0), .RESET_VAL('0)) u_sec (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .carry_in(tick),
        .limit(SEC_LIMIT), .load(set), .load_value('0),
        .count(sec_cur), .count_next(sec_nxt), .carry_out(sec_carry)
    );

    ccc_cell #(.WIDTH(MIN_W), .FIRST('0), .RESET_VAL('0)) u_min (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .carry_in(sec_carry),
        .limit(MIN_LIMIT), .load(set), .load_value(set_m),
        .count(min_cur), .count_next(min_nxt), .carry_out(min_carry)
    );

    ccc_cell #(.WIDTH(HOUR_W), .FIRST('0), .RESET_VAL('0)) u_hour (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .carry_in(min_carry),
        .limit(HOUR_LIMIT), .load(set), .load_value(set_h),
        .count(hour_cur), .count_next(hour_nxt), .carry_out(hour_carry)
    );

    // day wraps once it passes the month length
    assign day_limit = (DAY_W+1)'(days_in_month(month_cur, leap)) + (DAY_W+1)'(1);

    ccc_cell #(.WIDTH(DAY_W), .FIRST(5'd1), .RESET_VAL(5'd1)) u_day (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .carry_in(hour_carry),
        .limit(day_limit), .load(1'b0), .load_value('0),
        .count(day_cur), .count_next(day_nxt), .carry_out(day_carry)
    );

    ccc_cell #(.WIDTH(MONTH_W), .FIRST(4'd1), .RESET_VAL(4'd1)) u_month (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .carry_in(day_carry),
        .limit(MONTH_LIMIT), .load(1'b0), .load_value('0),
        .count(month_cur), .count_next(month_nxt), .carry_out(month_carry)
    );

    ccc_cell #(.WIDTH(YEAR_W), .FIRST('0), .RESET_VAL(YEAR_RESET)) u_year (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .carry_in(month_carry),
        .limit(YEAR_LIMIT), .load(1'b0), .load_value('0),
        .count(year_cur), .count_next(year_nxt), .carry_out(year_carry_unused)
    );

    ccc_leap u_leap (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .year_carry(month_carry),
        .year(year_cur), .leap(leap)
    );

    ccc_cell #(.WIDTH(TICK_W), .FIRST('0), .RESET_VAL('0)) u_tick (
        .clk(clk), .rst_n(rst_n), .advance(in_fire), .carry_in(tick),
        .limit(TICK_LIMIT), .load(1'b0), .load_value('0),
        .count(tick_cur), .count_next(tick_nxt), .carry_out(tick_carry_unused)
    );

    always_comb
    begin
        result.seconds    = sec_nxt;
        result.minutes    = min_nxt;
        result.hours      = hour_nxt;
        result.shown_hour = shown_hour_of(hour_nxt, hour_format_reg);
        result.after_noon = (hour_nxt >= 5'd12);
        result.day        = day_nxt;
        result.month      = month_nxt;
        result.year       = year_nxt;
        result.tick_total = tick_nxt;
    end

    assign out_take = out_valid_reg & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg <= skid_full_reg | in_fire;
            skid_full_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_full_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign seconds    = out_reg.seconds;
    assign minutes    = out_reg.minutes;
    assign hours      = out_reg.hours;
    assign shown_hour = out_reg.shown_hour;
    assign after_noon = out_reg.after_noon;
    assign day        = out_reg.day;
    assign month      = out_reg.month;
    assign year       = out_reg.year;
    assign tick_total = out_reg.tick_total;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode == MODE_TICK) |=> tick_cur == $past(tick_cur) + 32'd1)
        else $error("tick transfer did not advance tick count");

    a_set_keeps_date: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode == MODE_SET) |=> $stable(day_cur) && $stable(month_cur)
                                          && $stable(tick_cur))
        else $error("set transfer changed date or tick count");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_cur < 6'd60 && min_cur < 6'd60 && hour_cur < 5'd24)
        else $error("time of day out of range");
`endif

endmodule
